FILE: src/cdo_pkg.sv
// Package for the calendar date day offset block.
// Holds the field widths, the step unit's request types and the month length table.
// Used by cdo_step and calendar_date_day_offset; depends on nothing.
package cdo_pkg;

	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 6;
	localparam int OFS_W   = 16;
	localparam int R25_W   = 5;
	localparam int CNT_W   = OFS_W + 1;

	localparam logic signed [YEAR_W-1:0] YEAR_MIN     = 16'sh8000;
	localparam logic signed [YEAR_W-1:0] YEAR_MAX     = 16'sh7FFF;
	localparam logic signed [YEAR_W-1:0] MAX_YEAR_RST = 16'sd2020;

	localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

	// Reciprocal of 25 scaled by 2^17; exact for magnitudes up to 32768.
	localparam int RECIP_SHIFT = 17;
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam logic [R25_W-1:0] R25_TOP = 5'd24;

	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic [R25_W-1:0]         r25;   // year mod 25, in 0..24
		logic                     back;  // 1 steps one day back
	} step_req_t;

	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic [R25_W-1:0]         r25;
		logic                     blocked;  // step would leave the year range
	} step_rsp_t;

	// Gregorian leap rule from the low year bits and the year's residue mod 25.
	function automatic logic is_leap(logic signed [YEAR_W-1:0] y, logic [R25_W-1:0] r);
		is_leap = (y[1:0] == 2'b00) && ((r != '0) || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 6'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 6'd30;
			4'd2:                                       month_len = leap ? 6'd29 : 6'd28;
			default:                                    month_len = 6'd0;
		endcase
	endfunction

endpackage

FILE: src/cdo_step.sv
// One-day date step unit: moves a date one day forward or back with rollover.
// Shared by every iteration of the sequencer in calendar_date_day_offset.
// Depends on cdo_pkg.
module cdo_step (
	input  cdo_pkg::step_req_t req,
	output cdo_pkg::step_rsp_t rsp
);

	logic                          leap;
	logic [cdo_pkg::DAY_W-1:0]     len_cur;
	logic [cdo_pkg::DAY_W-1:0]     len_prev;
	logic [cdo_pkg::MONTH_W-1:0]   month_prev;

	assign leap       = cdo_pkg::is_leap(req.year, req.r25);
	assign month_prev = req.month - cdo_pkg::MONTH_W'(1);
	assign len_cur    = cdo_pkg::month_len(req.month, leap);
	assign len_prev   = cdo_pkg::month_len(month_prev, leap);

	always_comb begin
		rsp.year    = req.year;
		rsp.month   = req.month;
		rsp.day     = req.day;
		rsp.r25     = req.r25;
		rsp.blocked = 1'b0;
		if (!req.back) begin
			if (req.day < len_cur) begin
				rsp.day = req.day + cdo_pkg::DAY_W'(1);
			end else if (req.month < cdo_pkg::M_DEC) begin
				rsp.month = req.month + cdo_pkg::MONTH_W'(1);
				rsp.day   = cdo_pkg::DAY_W'(1);
			end else if (req.year != cdo_pkg::YEAR_MAX) begin
				rsp.year  = req.year + cdo_pkg::YEAR_W'(1);
				rsp.month = cdo_pkg::M_JAN;
				rsp.day   = cdo_pkg::DAY_W'(1);
				rsp.r25   = (req.r25 == cdo_pkg::R25_TOP) ? '0 : req.r25 + cdo_pkg::R25_W'(1);
			end else begin
				rsp.blocked = 1'b1;
			end
		end else begin
			if (req.day > cdo_pkg::DAY_W'(1)) begin
				rsp.day = req.day - cdo_pkg::DAY_W'(1);
			end else if (req.month > cdo_pkg::M_JAN) begin
				rsp.month = month_prev;
				rsp.day   = len_prev;
			end else if (req.year != cdo_pkg::YEAR_MIN) begin
				rsp.year  = req.year - cdo_pkg::YEAR_W'(1);
				rsp.month = cdo_pkg::M_DEC;
				rsp.day   = cdo_pkg::DAY_W'(31);
				rsp.r25   = (req.r25 == '0) ? cdo_pkg::R25_TOP : req.r25 - cdo_pkg::R25_W'(1);
			end else begin
				rsp.blocked = 1'b1;
			end
		end
	end

endmodule

FILE: src/calendar_date_day_offset.sv
// Top level of the calendar date day offset block: sequencer, registers, ports.
// Checks a Gregorian date and moves it by a signed day count, one day per cycle.
// Depends on cdo_pkg and cdo_step.
//
//  channel   dir  fields (lowest bit first)
//  s_*       in   in_year[15:0] in_month[19:16] in_day[25:20] day_offset[41:26]
//  m_*       out  out_year[15:0] out_month[19:16] out_day[25:20] input_is_leap[26]
//                 input_is_valid[27] year_overflow[28]
//  cfg_*     in   max_valid_year[15:0], written when cfg_we is high
//
// A request passes through acceptance, the mod-25 multiply, the validity check,
// one pass of the step unit per day and the load of the result register. An
// invalid date skips the stepping; a stop at the year range bound sets the
// overflow flag and ends the stepping early.
// s_tready is high only while the sequencer is idle; a finished result moves to
// the output register once that is free, so the next request can be taken while
// the previous result still waits. Reset clears control and sets max_valid_year to 2020.
module calendar_date_day_offset (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // in_year, in_month, in_day, day_offset, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_year, out_month, out_day, input_is_leap,
	                               // input_is_valid, year_overflow, zero fill
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata  // max_valid_year
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_STEP = 4'b1000
	} state_t;

	state_t state_q;

	logic signed [cdo_pkg::YEAR_W-1:0] max_year_q;
	logic signed [cdo_pkg::YEAR_W-1:0] year_q;
	logic [cdo_pkg::MONTH_W-1:0]       month_q;
	logic [cdo_pkg::DAY_W-1:0]         day_q;
	logic [cdo_pkg::R25_W-1:0]         r25_q;
	logic [cdo_pkg::OFS_W-1:0]         ofs_q;
	logic [cdo_pkg::CNT_W-1:0]         cnt_q;
	logic [cdo_pkg::CNT_W-1:0]         mag_q;
	logic [29:0]                       prod_q;
	logic                              back_q;
	logic                              leap_q;
	logic                              valid_q;
	logic                              ovf_q;

	logic                              m_tvalid_q;
	logic signed [cdo_pkg::YEAR_W-1:0] out_year_q;
	logic [cdo_pkg::MONTH_W-1:0]       out_month_q;
	logic [cdo_pkg::DAY_W-1:0]         out_day_q;
	logic                              out_leap_q;
	logic                              out_valid_q;
	logic                              out_ovf_q;

	cdo_pkg::step_req_t step_req;
	cdo_pkg::step_rsp_t step_rsp;

	logic [cdo_pkg::CNT_W-1:0]   q25;
	logic [cdo_pkg::CNT_W-1:0]   rem_full;
	logic [cdo_pkg::R25_W-1:0]   rem;
	logic [cdo_pkg::R25_W-1:0]   r25_init;
	logic                        leap_in;
	logic                        valid_in;
	logic                        out_free;
	logic                        done;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_ovf_q, out_valid_q, out_leap_q,
	                   out_day_q, out_month_q, out_year_q};

	// Remainder of |year| by 25 from the registered reciprocal product.
	assign q25      = {4'b0000, prod_q[29:cdo_pkg::RECIP_SHIFT]};
	assign rem_full = mag_q - cdo_pkg::CNT_W'(q25 * cdo_pkg::CNT_W'(25));
	assign rem      = rem_full[cdo_pkg::R25_W-1:0];
	assign r25_init = (year_q[cdo_pkg::YEAR_W-1] && rem != '0) ?
	                  cdo_pkg::R25_W'(25) - rem : rem;
	assign leap_in  = cdo_pkg::is_leap(year_q, rem);
	assign valid_in = (year_q <= max_year_q) && (month_q >= cdo_pkg::M_JAN) &&
	                  (month_q <= cdo_pkg::M_DEC) && (day_q != '0) &&
	                  (day_q <= cdo_pkg::month_len(month_q, leap_in));

	assign step_req.year  = year_q;
	assign step_req.month = month_q;
	assign step_req.day   = day_q;
	assign step_req.r25   = r25_q;
	assign step_req.back  = back_q;

	cdo_step u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign done     = (cnt_q == '0) || ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_year_q <= cdo_pkg::MAX_YEAR_RST;
		end else if (cfg_we) begin
			max_year_q <= cfg_wdata;
		end
	end

	// A new result may replace one that leaves at the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_STEP && done && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					year_q  <= s_tdata[15:0];
					month_q <= s_tdata[19:16];
					day_q   <= s_tdata[25:20];
					ofs_q   <= s_tdata[41:26];
					mag_q   <= s_tdata[15] ? cdo_pkg::CNT_W'(-$signed({s_tdata[15], s_tdata[15:0]}))
					                       : {1'b0, s_tdata[15:0]};
				end
			end
			ST_MUL: begin
				prod_q <= 30'(mag_q * cdo_pkg::RECIP_25);
				back_q <= ofs_q[cdo_pkg::OFS_W-1];
			end
			ST_CHK: begin
				r25_q   <= r25_init;
				leap_q  <= leap_in;
				valid_q <= valid_in;
				ovf_q   <= 1'b0;
				// An invalid date skips stepping and leaves the fields unchanged.
				if (!valid_in) begin
					cnt_q <= '0;
				end else if (back_q) begin
					cnt_q <= cdo_pkg::CNT_W'(-$signed({ofs_q[cdo_pkg::OFS_W-1], ofs_q}));
				end else begin
					cnt_q <= {1'b0, ofs_q};
				end
			end
			ST_STEP: begin
				if (done) begin
					if (out_free) begin
						out_year_q  <= year_q;
						out_month_q <= month_q;
						out_day_q   <= day_q;
						out_leap_q  <= leap_q;
						out_valid_q <= valid_q;
						out_ovf_q   <= ovf_q;
					end
				end else if (step_rsp.blocked) begin
					ovf_q <= 1'b1;
				end else begin
					year_q  <= step_rsp.year;
					month_q <= step_rsp.month;
					day_q   <= step_rsp.day;
					r25_q   <= step_rsp.r25;
					cnt_q   <= cnt_q - cdo_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/calendar_date_day_offset_check.sv
// Checker for the calendar date day offset block: watches the request, result and
// register write ports, predicts each result and compares it field by field.
// Depends on cdo_pkg for the field widths and the year range bounds.
module calendar_date_day_offset_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // in_year, in_month, in_day, day_offset, zero fill
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // out_year, out_month, out_day, input_is_leap,
	                               // input_is_valid, year_overflow, zero fill
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata, // max_valid_year
	output int          date_mismatches,
	output int          dates_in_flight
);

	typedef struct {
		logic signed [cdo_pkg::YEAR_W-1:0] year;
		logic [cdo_pkg::MONTH_W-1:0]       month;
		logic [cdo_pkg::DAY_W-1:0]         day;
		logic                              leap;
		logic                              valid;
		logic                              overflow;
	} shifted_date_t;

	shifted_date_t expected_dates[$];
	int max_year = cdo_pkg::MAX_YEAR_RST;

	// Exact divisibility also holds for negative years, so year 0 and -400 are leap years.
	function automatic bit leap_year(int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(int y, int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic shifted_date_t shift_date(logic [47:0] req, int limit);
		int y;
		int m;
		int d;
		int n;
		shifted_date_t r;
		y = $signed(req[15:0]);
		m = req[19:16];
		d = req[25:20];
		n = $signed(req[41:26]);
		r.leap = leap_year(y);
		r.valid = (y <= limit) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(y, m));
		r.overflow = 1'b0;
		// An invalid date skips both loops and comes back unchanged.
		if (r.valid) begin
			while (n > 0 && !r.overflow) begin
				if (d < month_days(y, m)) begin
					d++;
				end else if (m < cdo_pkg::M_DEC) begin
					m++;
					d = 1;
				end else if (y < cdo_pkg::YEAR_MAX) begin
					y++;
					m = cdo_pkg::M_JAN;
					d = 1;
				end else begin
					r.overflow = 1'b1;
				end
				if (!r.overflow) n--;
			end
			while (n < 0 && !r.overflow) begin
				if (d > 1) begin
					d--;
				end else if (m > cdo_pkg::M_JAN) begin
					m--;
					d = month_days(y, m);
				end else if (y > cdo_pkg::YEAR_MIN) begin
					y--;
					m = cdo_pkg::M_DEC;
					d = 31;
				end else begin
					r.overflow = 1'b1;
				end
				if (!r.overflow) n++;
			end
		end
		r.year = y[15:0];
		r.month = m[3:0];
		r.day = d[5:0];
		return r;
	endfunction

	task automatic report(string what);
		$display("%0t: %s", $time, what);
		date_mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		shifted_date_t want;
		if (!arst_n) begin
			expected_dates.delete();
			max_year = cdo_pkg::MAX_YEAR_RST;
			date_mismatches = 0;
		end else begin
			// Results are handled first: a result can never belong to the request
			// accepted at the same edge.
			if (m_tvalid && m_tready) begin
				if (expected_dates.size() == 0) begin
					report($sformatf("result %h with no request waiting", m_tdata));
				end else begin
					want = expected_dates.pop_front();
					if ($signed(m_tdata[15:0]) != want.year)
						report($sformatf("out_year %0d, expected %0d",
							$signed(m_tdata[15:0]), want.year));
					if (m_tdata[19:16] != want.month)
						report($sformatf("out_month %0d, expected %0d",
							m_tdata[19:16], want.month));
					if (m_tdata[25:20] != want.day)
						report($sformatf("out_day %0d, expected %0d",
							m_tdata[25:20], want.day));
					if (m_tdata[26] != want.leap)
						report($sformatf("input_is_leap %0b, expected %0b",
							m_tdata[26], want.leap));
					if (m_tdata[27] != want.valid)
						report($sformatf("input_is_valid %0b, expected %0b",
							m_tdata[27], want.valid));
					if (m_tdata[28] != want.overflow)
						report($sformatf("year_overflow %0b, expected %0b",
							m_tdata[28], want.overflow));
				end
			end
			if (s_tvalid && s_tready) begin
				want = shift_date(s_tdata, max_year);
				expected_dates.insert(expected_dates.size(), want);
			end
			if (cfg_we)
				max_year = $signed(cfg_wdata);
		end
		dates_in_flight = expected_dates.size();
	end

endmodule

FILE: tb/calendar_date_day_offset_test.sv
// Top of the calendar date day offset testbench: clock, reset, requests, result
// back-pressure, register writes and the verdict.
// Depends on cdo_pkg, calendar_date_day_offset and calendar_date_day_offset_check.
module calendar_date_day_offset_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // in_year, in_month, in_day, day_offset, zero fill
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // out_year, out_month, out_day, input_is_leap,
	                             // input_is_valid, year_overflow, zero fill
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0; // max_valid_year
	int          date_mismatches;
	int          dates_in_flight;
	bit          calm = 1'b0;
	int          stall_left = 0;

	calendar_date_day_offset DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	calendar_date_day_offset_check checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.date_mismatches (date_mismatches),
		.dates_in_flight (dates_in_flight)
	);

	always #5 clk = ~clk;

	// Result back-pressure: random stall bursts, no new burst once the run turns calm.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(1, 18) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	// Valid stays high between back-to-back requests.
	task automatic send_date(input int y, input int mon, input int d, input int ofs);
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, 16'(ofs), 6'(d), 4'(mon), 16'(y)};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_for_results;
		s_tvalid <= 1'b0;
		while (dates_in_flight != 0) @(negedge clk);
	endtask

	// Every request gives a result, so the block is idle once none is outstanding.
	task automatic write_max_year(input int v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= 16'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int y;
		int mon;
		int d;
		int ofs;
		int lim;
		int pick;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Leap rules, month and year rollover, invalid dates, range bounds.
		send_date(2020, 2, 28, 1);
		send_date(2019, 2, 28, 1);
		send_date(1900, 2, 28, 1);
		send_date(2000, 2, 29, 0);
		send_date(2019, 12, 31, 1);
		send_date(2020, 1, 1, -1);
		send_date(2020, 3, 1, -1);
		send_date(2021, 1, 1, 5);
		send_date(2020, 0, 10, 3);
		send_date(2020, 15, 63, 3);
		send_date(2020, 4, 31, 1);
		send_date(2020, 5, 0, 2);
		send_date(0, 2, 29, 1);
		send_date(-4, 2, 29, -1);
		send_date(-100, 2, 29, 1);
		send_date(-400, 2, 29, 365);
		send_date(-32768, 1, 1, -1);
		send_date(-32768, 1, 5, -10);
		send_date(2000, 6, 15, 32767);
		send_date(2000, 6, 15, -32768);
		write_max_year(cdo_pkg::YEAR_MAX);
		send_date(32767, 12, 31, 1);
		send_date(32767, 12, 25, 32767);
		send_date(32767, 2, 28, 1);
		write_max_year(cdo_pkg::YEAR_MIN);
		send_date(-32768, 3, 1, -1);
		send_date(-32767, 1, 1, 1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       lim = $urandom_range(0, 65535) - 32768;
				1:       lim = cdo_pkg::YEAR_MAX;
				2:       lim = $urandom_range(1582, 2500);
				default: lim = cdo_pkg::MAX_YEAR_RST;
			endcase
			calm = (phase == 3);
			write_max_year(lim);
			repeat (19) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					y = $urandom_range(0, 65535) - 32768;
					mon = $urandom_range(0, 15);
					d = $urandom_range(0, 63);
				end else begin
					case ($urandom_range(0, 2))
						0: y = $urandom_range(1500, 2100);
						1: y = $urandom_range(0, 65535) - 32768;
						default: y = $urandom_range(0, 1) ? $urandom_range(0, 8) - 32768
						                                 : 32767 - $urandom_range(0, 8);
					endcase
					// Most dates should pass the year check so the stepping gets exercised.
					if (y > lim) y = lim - $urandom_range(0, 40);
					if (y < -32768) y = -32768;
					mon = $urandom_range(1, 12);
					d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
					                                : $urandom_range(1, 28);
				end
				pick = $urandom_range(0, 99);
				if (pick < 5)
					ofs = 0;
				else if (pick < 60)
					ofs = $urandom_range(0, 800) - 400;
				else if (pick < 93)
					ofs = $urandom_range(0, 6000) - 3000;
				else
					ofs = $urandom_range(0, 65535) - 32768;
				send_date(y, mon, d, ofs);
			end
		end

		wait_for_results();
		repeat (40) @(negedge clk);
		if (date_mismatches == 0)
			$display("calendar_date_day_offset_test: clean");
		else
			$display("calendar_date_day_offset_test: errors");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("calendar_date_day_offset_test: errors");
		$finish;
	end

endmodule
